// ----- rtl/shabc_pkg.sv -----
// shared types, constants and round tables for the sha-256 compression engine
package shabc_pkg;

  localparam int WordW     = 32;
  localparam int NumChain  = 8;
  localparam int NumWin    = 16;
  localparam int NumRounds = 64;

  typedef logic [WordW-1:0] word_t;

  // item opcodes
  localparam logic [1:0] OP_WORD = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  localparam word_t ROUND_K [NumRounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t H_INIT [NumChain] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // commands from the controller to the datapath
  typedef struct packed {
    logic       win_shift;
    logic       chain_load;
    logic       chain_init;
    logic       work_init;
    logic       round_step;
    logic [5:0] round_idx;
    logic       final_add;
    logic       emit_load;
    logic [2:0] emit_idx;
  } dp_cmd_t;

endpackage

// ----- rtl/shabc_ifs.sv -----
// valid/ready channel interfaces for the input items and the digest words
interface shabc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  chain_index;
  logic [31:0] value;

  modport source (output valid, op, chain_index, value, input ready);
  modport sink   (input valid, op, chain_index, value, output ready);
endinterface

interface shabc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        last;

  modport source (output valid, digest_word, digest_index, last, input ready);
  modport sink   (input valid, digest_word, digest_index, last, output ready);
endinterface

// ----- rtl/shabc_datapath.sv -----
// schedule window, working variables, chaining value and output register
module shabc_datapath
  import shabc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  logic [2:0] in_chain_index,
  input  word_t   in_value,
  output word_t   out_digest_word,
  output logic [2:0] out_digest_index,
  output logic    out_last
);

  function automatic word_t rotr(word_t x, int unsigned r);
    return (x >> r) | (x << (WordW - r));
  endfunction

  word_t win_r   [NumWin];
  word_t chain_r [NumChain];
  word_t work_r  [NumChain];
  word_t digest_r;
  logic [2:0] index_r;
  logic  last_r;

  word_t w_new, win_in;
  word_t s0, s1, bs0, bs1, chv, majv, t1, t2;

  // next schedule word: w[t+16] from taps t, t+1, t+9, t+14
  always_comb begin
    s0     = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1     = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new  = win_r[0] + s0 + win_r[9] + s1;
    win_in = cmd.round_step ? w_new : in_value;
  end

  // one compression round
  always_comb begin
    bs0  = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    bs1  = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    majv = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    chv  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1   = work_r[7] + bs1 + chv + ROUND_K[cmd.round_idx] + win_r[0];
    t2   = bs0 + majv;
  end

  always_ff @(posedge clk) begin
    if (cmd.win_shift || cmd.round_step) begin
      for (int i = 0; i < NumWin - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[NumWin-1] <= win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.work_init) begin
      for (int i = 0; i < NumChain; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round_step) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumChain; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else if (cmd.chain_init) begin
      for (int i = 0; i < NumChain; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else if (cmd.chain_load) begin
      chain_r[in_chain_index] <= in_value;
    end else if (cmd.final_add) begin
      for (int i = 0; i < NumChain; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      digest_r <= chain_r[cmd.emit_idx];
      index_r  <= cmd.emit_idx;
      last_r   <= (cmd.emit_idx == 3'd7);
    end
  end

  assign out_digest_word  = digest_r;
  assign out_digest_index = index_r;
  assign out_last         = last_r;

endmodule

// ----- rtl/shabc_ctrl.sv -----
// sequencer: word collection, round count, final add and digest emission
module shabc_ctrl
  import shabc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.round_idx = round_r;
    cmd.emit_idx  = emit_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        cmd.win_shift  = accept && (in_op == OP_WORD);
        cmd.chain_load = accept && (in_op == OP_LOAD);
        cmd.chain_init = accept && (in_op == OP_INIT);
        if (cmd.win_shift) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            cmd.work_init = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        round_nxt      = round_r + 6'd1;
        if (round_r == 6'(NumRounds - 1)) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.final_add = 1'b1;
        emit_nxt      = '0;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit_load = 1'b1;
          out_valid_nxt = 1'b1;
          emit_nxt      = emit_r + 3'd1;
          if (emit_r == 3'd7) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      cnt_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      cnt_r       <= cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/sha256_block_compression.sv -----
// top level of the sha-256 compression engine
// sha-256 compression engine. message words (op 0) stream in big-endian word
// order; every sixteenth word completes a block, which is compressed into the
// eight-word chaining value and then sent out as eight digest words, index 0
// first, with last set on index 7. op 1 loads one chaining word, op 2 restores
// the standard initial hash value; neither touches a partly collected block,
// and op 3 is taken and ignored. the engine takes one input item per cycle
// while it is collecting. the sixteenth word starts the 64 rounds on the single
// round unit, followed by the chaining add; the eight digest words then leave
// at one per cycle while the sink is ready. input ready is low from the
// sixteenth word until the last digest word is in the output register; that
// word may still wait there while new items are taken
module sha256_block_compression
  import shabc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  shabc_in_if.sink    in_ch,
  shabc_out_if.source out_ch
);

  dp_cmd_t cmd;

  // sequencer: decides per cycle what the datapath does
  shabc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: schedule window, round unit, chaining value, output payload
  shabc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_chain_index   (in_ch.chain_index),
    .in_value         (in_ch.value),
    .out_digest_word  (out_ch.digest_word),
    .out_digest_index (out_ch.digest_index),
    .out_last         (out_ch.last)
  );

endmodule

// ----- tb/sv/sha256_block_compression_tb.sv -----
// self-checking testbench for the sha-256 compression engine
`timescale 1ns / 100ps

module sha256_block_compression_tb
  import shabc_pkg::*;
();

  // op 3 has no name in the package; the engine takes it and does nothing
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ClkHalf       = 6;
  localparam int TimeoutCycles = 200000;
  // a block needs 64 rounds, the chaining add and eight digest words
  localparam int DrainCycles   = 120;

  // one digest word as it should leave the engine
  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_t;

  logic clk = 1'b0;
  logic rst_n;

  shabc_in_if  in_ch ();
  shabc_out_if out_ch ();

  sha256_block_compression dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // predicted engine state: chaining value, partly collected block, fill count
  word_t      chain_state [NumChain];
  word_t      block_buf   [NumWin];
  logic [3:0] fill_cnt;

  // digest words still owed by the engine, oldest first
  digest_t digest_q [$];
  int      n_errors = 0;

  // random idling on both sides; cleared for the closing stretch
  bit idle_on = 1'b1;
  // long receiver hold-off, picked up and counted down by the receiver
  int hold_for = 0;

  function automatic word_t ror32(word_t x, int unsigned r);
    return (x >> r) | (x << (WordW - r));
  endfunction

  // one full compression of block_buf into chain_state
  function automatic void compress_block();
    word_t sched [NumRounds];
    word_t v [NumChain];
    word_t s0, s1, t1, t2, maj, ch;
    int    t;
    for (t = 0; t < NumWin; t++) sched[t] = block_buf[t];
    for (t = NumWin; t < NumRounds; t++) begin
      s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
    end
    for (t = 0; t < NumChain; t++) v[t] = chain_state[t];
    for (t = 0; t < NumRounds; t++) begin
      s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[t] + sched[t];
      s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (t = 0; t < NumChain; t++) chain_state[t] = chain_state[t] + v[t];
  endfunction

  // advance the predicted state by one accepted item and queue its digest words
  function automatic void predict_item(logic [1:0] op, logic [2:0] idx, word_t val);
    digest_t d;
    int      k;
    case (op)
      OP_LOAD: chain_state[idx] = val;
      OP_INIT: for (k = 0; k < NumChain; k++) chain_state[k] = H_INIT[k];
      OP_WORD: begin
        block_buf[fill_cnt] = val;
        if (fill_cnt == 4'd15) begin
          fill_cnt = 4'd0;
          compress_block();
          for (k = 0; k < NumChain; k++) begin
            d.word  = chain_state[k];
            d.index = k[2:0];
            d.last  = (k == NumChain - 1);
            digest_q.push_back(d);
          end
        end else begin
          fill_cnt = fill_cnt + 4'd1;
        end
      end
      default: ;  // unused op: no state change, no result
    endcase
  endfunction

  // message word biased toward the corners of the 32-bit range
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, WordW - 1);
      3:       return ~(word_t'(1) << $urandom_range(0, WordW - 1));
      default: return $urandom;
    endcase
  endfunction

  // drive one item at the falling edge and hold it until the transfer happens;
  // valid stays high into the next item unless a gap is inserted
  task automatic send_item(logic [1:0] op, logic [2:0] idx, word_t val);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.chain_index <= idx;
    in_ch.value       <= val;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, idx, val);
  endtask

  // receiver: random stall bursts, plus the long hold-off when one is requested
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_for > 0) begin
        hold_left = hold_for;
        hold_for  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // every digest transfer is compared against the oldest predicted word
  always @(posedge clk) begin : digest_check
    digest_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h index %0d", out_ch.digest_word,
               out_ch.digest_index);
        n_errors++;
      end else begin
        want = digest_q.pop_front();
        if (out_ch.digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_ch.digest_word);
          n_errors++;
        end
        if (out_ch.digest_index !== want.index) begin
          $error("digest_index: expected %0d, got %0d", want.index,
                 out_ch.digest_index);
          n_errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          n_errors++;
        end
      end
    end
  end

  // ops outside a block: restore, load both end words, then an ignored op
  task automatic test_op_codes();
    send_item(OP_INIT, 3'd0, '0);
    send_item(OP_LOAD, 3'd0, '0);
    send_item(OP_LOAD, 3'd7, '1);
    send_item(OP_UNUSED, 3'd7, '1);
  endtask

  // one block of all-zero / all-one words; the chaining value is reset and
  // reloaded part way through, which must not disturb the collected words
  task automatic test_chain_changes_mid_block();
    int k;
    for (k = 0; k < NumWin; k++) begin
      if (k == 4)  send_item(OP_INIT, 3'd5, 32'h1234_5678);
      if (k == 9)  send_item(OP_LOAD, 3'd3, 32'h8000_0001);
      if (k == 12) send_item(OP_UNUSED, 3'd2, 32'hA5A5_A5A5);
      send_item(OP_WORD, k[2:0], k[0] ? '1 : '0);
    end
  endtask

  // receiver holds off long enough that the engine stalls its input with a
  // whole second block still being offered
  task automatic test_output_backpressure();
    int k;
    hold_for = 400;
    for (k = 0; k < 2 * NumWin; k++) begin
      if (k == 7) send_item(OP_LOAD, 3'd6, pick_word());
      send_item(OP_WORD, 3'($urandom_range(0, 7)), pick_word());
    end
  endtask

  // mostly whole blocks with random words and the odd chaining op inside,
  // with short runs of arbitrary items as noise
  task automatic test_random_streams(int unsigned n_items);
    int unsigned sent;
    int          k;
    logic [1:0]  op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) != 0) begin
        for (k = 0; k < NumWin; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            op = 2'($urandom_range(1, 3));
            send_item(op, 3'($urandom_range(0, 7)), pick_word());
            if (op != OP_UNUSED) sent++;
          end
          send_item(OP_WORD, 3'($urandom_range(0, 7)), pick_word());
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 20)) begin
          op = 2'($urandom_range(0, 3));
          send_item(op, 3'($urandom_range(0, 7)), pick_word());
          if (op != OP_UNUSED) sent++;
        end
      end
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back_blocks();
    idle_on = 1'b0;
    repeat (3 * NumWin) send_item(OP_WORD, 3'($urandom_range(0, 7)), pick_word());
  endtask

  initial begin : main
    int k;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WORD;
    in_ch.chain_index = '0;
    in_ch.value       = '0;
    rst_n             = 1'b0;
    for (k = 0; k < NumChain; k++) chain_state[k] = H_INIT[k];
    for (k = 0; k < NumWin; k++) block_buf[k] = '0;
    fill_cnt = 4'd0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_op_codes();
    test_chain_changes_mid_block();
    test_output_backpressure();
    test_random_streams(220);
    test_back_to_back_blocks();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // wait for the owed words, then watch a while for anything extra
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (n_errors == 0) begin
      $display("sha256_block_compression_tb: done, clean");
    end else begin
      $display("sha256_block_compression_tb: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #(TimeoutCycles * 2 * ClkHalf);
    $display("sha256_block_compression_tb: done, errors");
    $finish;
  end

endmodule
